// ===== hw/rtl/svpwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg: shared constants for the SVPWM sector duty unit
// Fixed-point constants, sector codes and the exact projection sign test.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	localparam int VOLT_WIDTH_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	// unsigned Q1.16 duty / active-time width and constants
	localparam int            Q_WIDTH   = 17;
	localparam int            FRAC_BITS = 16;
	localparam logic [16:0]   ONE_Q16   = 17'h10000;
	localparam logic [16:0]   HALF_Q16  = 17'h08000;

	// sqrt(3) in Q16
	localparam int SQRT3_Q16 = 113512;

	localparam int PERIOD_RESET = 8500;

	// sector codes: bit0 Vr1>0, bit1 Vr2>0, bit2 Vr3>0
	localparam logic [2:0] SECT_NONE  = 3'd0;
	localparam logic [2:0] SECT_1     = 3'd1;
	localparam logic [2:0] SECT_2     = 3'd2;
	localparam logic [2:0] SECT_3     = 3'd3;
	localparam logic [2:0] SECT_4     = 3'd4;
	localparam logic [2:0] SECT_5     = 3'd5;
	localparam logic [2:0] SECT_6     = 3'd6;
	localparam logic [2:0] SECT_SEVEN = 3'd7;

	// exact sign of sqrt3*a - b from signs and the squares 3a^2 and b^2
	function automatic logic proj_pos(
		input logic a_pos,
		input logic a_neg,
		input logic b_pos,
		input logic b_neg,
		input logic a3_gt_b2,
		input logic b2_gt_a3
	);
		logic r;
		if (a_pos) begin
			r = !b_pos || a3_gt_b2;
		end else if (a_neg) begin
			r = b_neg && b2_gt_a3;
		end else begin
			r = b_neg;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/svpwm_sector_duty_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_sector_duty_unit: sector-based space vector PWM duty pipeline
// Turns an alpha/beta voltage request and bus voltage into three clamped
// compare counts, the sector code and an overmodulation flag.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_data (PWM period in counts)
//  in      | in_valid / in_stall   | alpha_voltage, beta_voltage, bus_voltage
//  out     | out_valid / out_stall | compare_a/b/c, sector_code, overmodulated
//
//  One request enters per cycle while the output is not stalled; each result
//  passes stages 1 to 3, the divider stages, stages 4 and 5 and the output
//  register. The two parallel restoring dividers take 17 one-bit steps.
//  Reset clears all valid bits and loads the period register with 8500.
//  A stalled output freezes the whole pipeline in place; in_stall rises in
//  the same cycle, so nothing is dropped or taken twice.
// ----------------------------------------------------------------------------
module svpwm_sector_duty_unit #(
	parameter int VOLT_WIDTH  = svpwm_pkg::VOLT_WIDTH_DEF,
	parameter int COUNT_WIDTH = svpwm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [COUNT_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VOLT_WIDTH-1:0]  alpha_voltage,
	input  logic signed [VOLT_WIDTH-1:0]  beta_voltage,
	input  logic [VOLT_WIDTH-2:0]         bus_voltage,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [COUNT_WIDTH-1:0]        compare_a,
	output logic [COUNT_WIDTH-1:0]        compare_b,
	output logic [COUNT_WIDTH-1:0]        compare_c,
	output logic [2:0]                    sector_code,
	output logic                          overmodulated
);
	import svpwm_pkg::*;

	localparam int VW = VOLT_WIDTH;
	localparam int CW = COUNT_WIDTH;
	localparam int KW = VW + 18;        // K * beta, signed
	localparam int PW = VW + 20;        // signed active-time numerators
	localparam int UW = VW + 19;        // clipped numerator magnitude
	localparam int SW = UW + 1;         // numerator sum / divisor
	localparam int RW = UW + 17;        // divider remainder
	localparam int QW = Q_WIDTH;
	localparam int DS = Q_WIDTH;        // divider steps, one quotient bit each
	localparam int MW = QW + CW;        // duty * period product

	localparam logic signed [KW-1:0] SQRT3_K = KW'(SQRT3_Q16);

	logic                 adv;
	logic [CW-1:0]        period_q;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= CW'(PERIOD_RESET);
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	// Advance everything unless a finished result is held by the consumer.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// --------------------------------------------- stage 1: squares and K*b
	logic [VW-1:0]          a_mag;
	logic [VW-1:0]          b_mag;
	logic [VW-2:0]          bus_fix;
	logic signed [KW-1:0]   b_ext;
	logic                   v_s1;
	logic signed [VW-1:0]   a_s1;
	logic signed [VW-1:0]   b_s1;
	logic [VW-2:0]          bus_s1;
	logic [2*VW-1:0]        asq_s1;
	logic [2*VW-1:0]        bsq_s1;
	logic signed [KW-1:0]   kb_s1;

	always_comb begin
		a_mag   = alpha_voltage[VW-1] ? (~alpha_voltage + {{(VW-1){1'b0}}, 1'b1})
			: alpha_voltage;
		b_mag   = beta_voltage[VW-1] ? (~beta_voltage + {{(VW-1){1'b0}}, 1'b1})
			: beta_voltage;
		// treat a zero bus as one count
		bus_fix = (bus_voltage == '0) ? {{(VW-2){1'b0}}, 1'b1} : bus_voltage;
		b_ext   = {{(KW-VW){beta_voltage[VW-1]}}, beta_voltage};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1   <= alpha_voltage;
			b_s1   <= beta_voltage;
			bus_s1 <= bus_fix;
			asq_s1 <= (2*VW)'(a_mag) * (2*VW)'(a_mag);
			bsq_s1 <= (2*VW)'(b_mag) * (2*VW)'(b_mag);
			kb_s1  <= b_ext * SQRT3_K;
		end
	end

	// ------------------------------ stage 2: sector code and X, Y, Z numerators
	logic [2*VW+1:0]        a3sq;
	logic [2*VW+1:0]        bsq_x;
	logic                   a_pos, a_neg, b_pos, b_neg, a3_gt, b2_gt;
	logic signed [PW-1:0]   a_w, kb_w, a3k;
	logic [2:0]             n_c;
	logic                   v_s2;
	logic [2:0]             n_s2;
	logic signed [PW-1:0]   x_s2, y_s2, z_s2;
	logic [VW-2:0]          bus_s2;

	always_comb begin
		a3sq  = {2'b00, asq_s1} + {1'b0, asq_s1, 1'b0};
		bsq_x = {2'b00, bsq_s1};
		a_neg = a_s1[VW-1];
		a_pos = !a_s1[VW-1] && (a_s1 != '0);
		b_neg = b_s1[VW-1];
		b_pos = !b_s1[VW-1] && (b_s1 != '0);
		a3_gt = a3sq > bsq_x;
		b2_gt = bsq_x > a3sq;
		n_c   = {proj_pos(a_neg, a_pos, b_pos, b_neg, a3_gt, b2_gt),
			proj_pos(a_pos, a_neg, b_pos, b_neg, a3_gt, b2_gt),
			b_pos};
		a_w   = {{(PW-VW){a_s1[VW-1]}}, a_s1};
		kb_w  = {{(PW-KW){kb_s1[KW-1]}}, kb_s1};
		a3k   = (a_w + (a_w <<< 1)) <<< FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s2   <= n_c;
			x_s2   <= kb_w <<< 1;
			y_s2   <= kb_w + a3k;
			z_s2   <= kb_w - a3k;
			bus_s2 <= bus_s1;
		end
	end

	// --------------- stage 3: pick active times, detect overmodulation, load divider
	logic signed [PW-1:0]   t1s, t2s;
	logic [UW-1:0]          u1, u2;
	logic [SW-1:0]          ssum;
	logic                   is_null, ovm_c;

	logic                   v_sd   [0:DS];
	logic [2:0]             n_sd   [0:DS];
	logic                   ovm_sd [0:DS];
	logic [RW-1:0]          rem1_sd[0:DS-1];
	logic [RW-1:0]          rem2_sd[0:DS-1];
	logic [SW-1:0]          den_sd [0:DS-1];
	logic [QW-1:0]          q1_sd  [0:DS];
	logic [QW-1:0]          q2_sd  [0:DS];

	always_comb begin
		case (n_s2)
			SECT_1: begin
				t1s = z_s2;   t2s = y_s2;
			end
			SECT_2: begin
				t1s = y_s2;   t2s = -x_s2;
			end
			SECT_3: begin
				t1s = -z_s2;  t2s = x_s2;
			end
			SECT_4: begin
				t1s = -x_s2;  t2s = z_s2;
			end
			SECT_5: begin
				t1s = x_s2;   t2s = -y_s2;
			end
			SECT_6: begin
				t1s = -y_s2;  t2s = -z_s2;
			end
			default: begin
				t1s = '0;     t2s = '0;
			end
		endcase
		// clip rounding spill at a sector edge
		u1      = t1s[PW-1] ? '0 : t1s[UW-1:0];
		u2      = t2s[PW-1] ? '0 : t2s[UW-1:0];
		ssum    = {1'b0, u1} + {1'b0, u2};
		is_null = (n_s2 == SECT_NONE) || (n_s2 == SECT_SEVEN);
		ovm_c   = !is_null && (ssum > SW'({bus_s2, 17'd0}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_sd[0]   <= n_s2;
			ovm_sd[0] <= ovm_c;
			q1_sd[0]  <= '0;
			q2_sd[0]  <= '0;
			if (ovm_c) begin
				// T = Tn * 2^16 / sum
				rem1_sd[0] <= RW'({u1, 16'd0});
				rem2_sd[0] <= RW'({u2, 16'd0});
				den_sd[0]  <= ssum;
			end else begin
				// T = Tn / (2 * bus)
				rem1_sd[0] <= RW'(u1);
				rem2_sd[0] <= RW'(u2);
				den_sd[0]  <= SW'({bus_s2, 1'b0});
			end
		end
	end

	// ------------------ divider stages: one quotient bit per stage, MSB first
	logic [RW-1:0] trial [0:DS-1];
	logic          take1 [0:DS-1];
	logic          take2 [0:DS-1];

	always_comb begin
		for (int k = 0; k < DS; k++) begin
			trial[k] = RW'(den_sd[k]) << (DS - 1 - k);
			take1[k] = rem1_sd[k] >= trial[k];
			take2[k] = rem2_sd[k] >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DS; k++) begin
				n_sd[k+1]   <= n_sd[k];
				ovm_sd[k+1] <= ovm_sd[k];
				q1_sd[k+1]  <= {q1_sd[k][QW-2:0], take1[k]};
				q2_sd[k+1]  <= {q2_sd[k][QW-2:0], take2[k]};
			end
			for (int k = 0; k < DS-1; k++) begin
				rem1_sd[k+1] <= take1[k] ? rem1_sd[k] - trial[k] : rem1_sd[k];
				rem2_sd[k+1] <= take2[k] ? rem2_sd[k] - trial[k] : rem2_sd[k];
				den_sd[k+1]  <= den_sd[k];
			end
		end
	end

	// --------------------------------- stage 4: duties and sector permutation
	logic [QW-1:0]  t1, t2c, da, db, dc, dsum;
	logic [QW:0]    tsum;
	logic           v_s4;
	logic [2:0]     n_s4;
	logic           ovm_s4;
	logic [QW-1:0]  duty_a_s4, duty_b_s4, duty_c_s4;
	logic [QW-1:0]  pa, pb, pc;

	always_comb begin
		t1   = q1_sd[DS];
		tsum = {1'b0, q1_sd[DS]} + {1'b0, q2_sd[DS]};
		t2c  = (tsum > {1'b0, ONE_Q16}) ? (ONE_Q16 - t1) : q2_sd[DS];
		dsum = ONE_Q16 - t1 - t2c;
		da   = dsum >> 1;
		db   = da + t2c;
		dc   = db + t1;
		case (n_sd[DS])
			SECT_1: begin
				pa = db;  pb = dc;  pc = da;
			end
			SECT_2: begin
				pa = dc;  pb = da;  pc = db;
			end
			SECT_3: begin
				pa = dc;  pb = db;  pc = da;
			end
			SECT_4: begin
				pa = da;  pb = db;  pc = dc;
			end
			SECT_5: begin
				pa = da;  pb = dc;  pc = db;
			end
			SECT_6: begin
				pa = db;  pb = da;  pc = dc;
			end
			default: begin
				// zero vector: every phase at half period
				pa = HALF_Q16;  pb = HALF_Q16;  pc = HALF_Q16;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s4      <= n_sd[DS];
			ovm_s4    <= ovm_sd[DS];
			duty_a_s4 <= pa;
			duty_b_s4 <= pb;
			duty_c_s4 <= pc;
		end
	end

	// -------------------------------------- stage 5: scale duties by period
	logic           v_s5;
	logic [2:0]     n_s5;
	logic           ovm_s5;
	logic [MW-1:0]  prod_a_s5, prod_b_s5, prod_c_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s5      <= n_s4;
			ovm_s5    <= ovm_s4;
			prod_a_s5 <= MW'(duty_a_s4) * MW'(period_q);
			prod_b_s5 <= MW'(duty_b_s4) * MW'(period_q);
			prod_c_s5 <= MW'(duty_c_s4) * MW'(period_q);
		end
	end

	// --------------------------------- output register: drop fraction, clamp
	logic [CW:0]    cnt_a, cnt_b, cnt_c;
	logic [CW-1:0]  cmp_a_q, cmp_b_q, cmp_c_q;
	logic [2:0]     sector_q;
	logic           ovm_q;
	logic           out_valid_q;

	always_comb begin
		cnt_a = prod_a_s5[MW-1:FRAC_BITS];
		cnt_b = prod_b_s5[MW-1:FRAC_BITS];
		cnt_c = prod_c_s5[MW-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmp_a_q  <= (cnt_a > {1'b0, period_q}) ? period_q : cnt_a[CW-1:0];
			cmp_b_q  <= (cnt_b > {1'b0, period_q}) ? period_q : cnt_b[CW-1:0];
			cmp_c_q  <= (cnt_c > {1'b0, period_q}) ? period_q : cnt_c[CW-1:0];
			sector_q <= n_s5;
			ovm_q    <= ovm_s5;
		end
	end

	// ------------------------------------------------------------ valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= DS; k++) begin
				v_sd[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_sd[0] <= v_s2;
			for (int k = 0; k < DS; k++) begin
				v_sd[k+1] <= v_sd[k];
			end
			v_s4        <= v_sd[DS];
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_a     = cmp_a_q;
	assign compare_b     = cmp_b_q;
	assign compare_c     = cmp_c_q;
	assign sector_code   = sector_q;
	assign overmodulated = ovm_q;

`ifndef SYNTHESIS
	// duties never exceed one after the active-time clamp
	a_duty_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (duty_a_s4 <= ONE_Q16) && (duty_b_s4 <= ONE_Q16)
			&& (duty_c_s4 <= ONE_Q16))
		else $error("duty above one");

	// zero vector puts every phase at half
	a_null_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ((n_s4 == SECT_NONE) || (n_s4 == SECT_SEVEN)) |->
			(duty_a_s4 == HALF_Q16) && (duty_b_s4 == HALF_Q16)
			&& (duty_c_s4 == HALF_Q16))
		else $error("zero vector duty not half");

	// overmodulation cannot be flagged for the zero vector
	a_null_no_ovm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((sector_code == SECT_NONE) || (sector_code == SECT_SEVEN))
			|-> !overmodulated)
		else $error("overmodulation on zero vector");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_svpwm_sector_duty_unit.sv =====
// ----------------------------------------------------------------------------
// tb_svpwm_sector_duty_unit: self-checking bench for the SVPWM duty unit
// Drives voltage requests under several idle/stall mixes and period settings,
// predicts compares, sector and overmodulation flag, and checks each result.
// ----------------------------------------------------------------------------
module tb_svpwm_sector_duty_unit;
	import svpwm_pkg::*;

	typedef struct packed {
		logic [15:0] cmp_a;
		logic [15:0] cmp_b;
		logic [15:0] cmp_c;
		logic [2:0]  sector;
		logic        ovm;
	} duty_result_t;

	// Scoreboard: predict duty results per request and compare in order.
	class duty_scoreboard;
		duty_result_t pending[$];
		int unsigned  mismatches;
		logic [15:0]  period;

		function new();
			period = 16'(PERIOD_RESET);
			mismatches = 0;
		endfunction

		// exact sign of sqrt3*a - b
		function bit proj_above(longint a, longint b);
			longint ua, ub, a3, b2;
			ua = a < 0 ? -a : a;
			ub = b < 0 ? -b : b;
			a3 = 3 * ua * ua;
			b2 = ub * ub;
			if (a > 0) return (b <= 0) || (a3 > b2);
			if (a == 0) return b < 0;
			if (b >= 0) return 0;
			return b2 > a3;
		endfunction

		function longint frac_q16(longint n, longint d);
			if (n >= d) return 65536;
			return (n * 65536) / d;
		endfunction

		function logic [15:0] scale_duty(longint duty);
			longint c;
			c = (duty * period) >>> 16;
			return c > period ? period : c[15:0];
		endfunction

		function void note_request(logic signed [15:0] al, logic signed [15:0] be,
				logic [14:0] vbus);
			longint a, b, bus, xn, yn, zn, t1s, t2s, u1, u2, s, t1, t2;
			longint da, db, dc, ta, tb, tc;
			logic [2:0] n;
			duty_result_t r;
			a = al; b = be; bus = vbus;
			if (bus == 0) bus = 1;
			n = '0;
			t1s = 0; t2s = 0;
			r.ovm = 0;
			if (b > 0) n[0] = 1;
			if (proj_above(a, b)) n[1] = 1;
			if (proj_above(-a, b)) n[2] = 1;
			xn = 2 * SQRT3_Q16 * b;
			yn = SQRT3_Q16 * b + 196608 * a;
			zn = SQRT3_Q16 * b - 196608 * a;
			case (n)
				SECT_1: begin t1s = zn; t2s = yn; end
				SECT_2: begin t1s = yn; t2s = -xn; end
				SECT_3: begin t1s = -zn; t2s = xn; end
				SECT_4: begin t1s = -xn; t2s = zn; end
				SECT_5: begin t1s = xn; t2s = -yn; end
				SECT_6: begin t1s = -yn; t2s = -zn; end
				default: ;
			endcase
			if (n == SECT_NONE || n == SECT_SEVEN) begin
				ta = 32768; tb = 32768; tc = 32768;
			end else begin
				u1 = t1s < 0 ? 0 : t1s;
				u2 = t2s < 0 ? 0 : t2s;
				s = u1 + u2;
				if (s > (bus << 17)) begin
					r.ovm = 1;
					t1 = frac_q16(u1, s);
					t2 = frac_q16(u2, s);
				end else begin
					t1 = u1 / (2 * bus);
					t2 = u2 / (2 * bus);
				end
				if (t1 + t2 > 65536) t2 = 65536 - t1;
				da = (65536 - t1 - t2) >>> 1;
				db = da + t2;
				dc = db + t1;
				case (n)
					SECT_1: begin ta = db; tb = dc; tc = da; end
					SECT_2: begin ta = dc; tb = da; tc = db; end
					SECT_3: begin ta = dc; tb = db; tc = da; end
					SECT_4: begin ta = da; tb = db; tc = dc; end
					SECT_5: begin ta = da; tb = dc; tc = db; end
					default: begin ta = db; tb = da; tc = dc; end
				endcase
			end
			r.cmp_a = scale_duty(ta);
			r.cmp_b = scale_duty(tb);
			r.cmp_c = scale_duty(tc);
			r.sector = n;
			pending.push_back(r);
		endfunction

		function void check_result(duty_result_t got);
			duty_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp a=%0d b=%0d c=%0d n=%0d ovm=%0d,",
						want.cmp_a, want.cmp_b, want.cmp_c, want.sector, want.ovm,
						" got a=%0d b=%0d c=%0d n=%0d ovm=%0d",
						got.cmp_a, got.cmp_b, got.cmp_c, got.sector, got.ovm);
			end
		endfunction
	endclass

	localparam int PIPE_LATENCY = 22;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] alpha_voltage = '0;
	logic signed [15:0] beta_voltage = '0;
	logic [14:0] bus_voltage = 15'd1;
	logic out_valid;
	logic out_stall = 0;
	logic [15:0] compare_a, compare_b, compare_c;
	logic [2:0] sector_code;
	logic overmodulated;

	duty_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	svpwm_sector_duty_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.alpha_voltage(alpha_voltage), .beta_voltage(beta_voltage),
		.bus_voltage(bus_voltage),
		.out_valid(out_valid), .out_stall(out_stall),
		.compare_a(compare_a), .compare_b(compare_b), .compare_c(compare_c),
		.sector_code(sector_code), .overmodulated(overmodulated)
	);

	always #4 clk = ~clk;

	// Watchdog: end the run if the pipeline hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: stall at random and check every accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result({compare_a, compare_b, compare_c, sector_code,
					overmodulated});
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Send one request; hold it until accepted, note it, then maybe idle.
	task automatic send_request(logic signed [15:0] al, logic signed [15:0] be,
			logic [14:0] vbus);
		alpha_voltage <= al;
		beta_voltage <= be;
		bus_voltage <= vbus;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(al, be, vbus);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_period(logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.period = value;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Mostly moderate magnitudes so both normal and overmodulated paths hit.
	task automatic send_random();
		logic signed [15:0] al, be;
		logic [14:0] vbus;
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) begin
			vbus = 15'($urandom_range(32767, 1));
			al = $signed(16'($urandom_range(2 * vbus))) - $signed(16'(vbus));
			be = $signed(16'($urandom_range(2 * vbus))) - $signed(16'(vbus));
		end else if (pick < 7) begin
			vbus = 15'($urandom_range(2000, 1));
			al = 16'($signed(16'($urandom_range(600))) - 300);
			be = 16'($signed(16'($urandom_range(600))) - 300);
		end else begin
			al = 16'($urandom);
			be = 16'($urandom);
			vbus = 15'($urandom);
		end
		send_request(al, be, vbus);
	endtask

	task automatic run_phase(int idle, int stall, int count);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) send_random();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero vector, field extremes, every sector, axis edges.
		send_request(0, 0, 100);
		send_request(0, 0, 0);
		send_request(16'sh7fff, 0, 15'h7fff);
		send_request(16'sh8000, 0, 1);
		send_request(0, 16'sh7fff, 1);
		send_request(0, 16'sh8000, 15'h7fff);
		send_request(16'sh7fff, 16'sh7fff, 0);
		send_request(16'sh8000, 16'sh8000, 15'h4000);
		send_request(1000, 577, 5000);
		send_request(1000, -577, 5000);
		send_request(100, 300, 1000);
		send_request(-100, 300, 1000);
		send_request(-100, -300, 1000);
		send_request(100, -300, 1000);
		send_request(-1000, 10, 800);
		send_request(26755, 15448, 100);
		send_request(1, 1, 32767);
		send_request(-1, 0, 1);
		send_request(1000, 1732, 600);
		send_request(-1000, 1732, 600);
		drain();

		write_period(16'hffff);
		run_phase(0, 0, 200);
		drain();
		write_period(16'd1);
		run_phase(66, 0, 150);
		drain();
		write_period(16'd0);
		run_phase(0, 66, 100);
		drain();
		write_period(16'd1000);
		run_phase(30, 30, 300);
		drain();
		write_period(16'(PERIOD_RESET));
		run_phase(0, 0, 250);
		drain();
		write_period(16'($urandom_range(65535, 2)));
		run_phase(66, 66, 250);
		run_phase(30, 30, 280);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_sector_duty_unit.sv
tb/sv/tb_svpwm_sector_duty_unit.sv
